[rtl/core/fac_pkg.sv]
`timescale 1ns / 1ps

package fac_pkg;

    localparam int COORD_W    = 16;
    localparam int COEF_W     = COORD_W + 1;
    localparam int PROD_W     = COEF_W + COORD_W;
    localparam int D_SHIFT    = 8;
    localparam int DSH_W      = COEF_W + D_SHIFT;
    localparam int ACC_W      = PROD_W + 3;
    localparam int ROW_DATA_W = 64;
    localparam int NUM_ROWS   = 4;
    localparam int ROW_IDX_W  = $clog2(NUM_ROWS);
    localparam int NUM_AXES   = 3;
    localparam int NUM_PLANES = 2 * NUM_AXES;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [COEF_W-1:0]  t_coef;

    typedef struct packed {
        t_coef [NUM_AXES-1:0] n;
        t_coef                d;
        logic                 zero;
    } t_plane;

    typedef struct packed {
        logic en_mul;
        logic en_sum;
    } t_stage_ctl;

    typedef enum logic [ROW_IDX_W-1:0] {
        ROW_X = 2'd0,
        ROW_Y = 2'd1,
        ROW_Z = 2'd2,
        ROW_W = 2'd3
    } t_row_idx;

    function automatic t_coef row_elem(input logic [ROW_DATA_W-1:0] row, input int k);
        t_coord e;
        e = t_coord'(row[k*COORD_W +: COORD_W]);
        return t_coef'(e);
    endfunction

endpackage

[rtl/core/fac_plane.sv]
`timescale 1ns / 1ps

module fac_plane (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [fac_pkg::ROW_IDX_W-1:0]  i_cfg_idx,
    input  logic [fac_pkg::ROW_DATA_W-1:0] i_cfg_data,
    output fac_pkg::t_plane                o_plane [fac_pkg::NUM_PLANES]
);
    import fac_pkg::*;

    logic [ROW_DATA_W-1:0] r_row_x;
    logic [ROW_DATA_W-1:0] r_row_y;
    logic [ROW_DATA_W-1:0] r_row_z;
    logic [ROW_DATA_W-1:0] r_row_w;
    logic [ROW_DATA_W-1:0] src_row [NUM_AXES];
    t_plane                n_plane [NUM_PLANES];
    t_plane                r_plane [NUM_PLANES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_x <= '0;
            r_row_y <= '0;
            r_row_z <= '0;
            r_row_w <= '0;
        end else if (i_cfg_we) begin
            case (t_row_idx'(i_cfg_idx))
                ROW_X:   r_row_x <= i_cfg_data;
                ROW_Y:   r_row_y <= i_cfg_data;
                ROW_Z:   r_row_z <= i_cfg_data;
                ROW_W:   r_row_w <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign src_row[0] = r_row_x;
    assign src_row[1] = r_row_y;
    assign src_row[2] = r_row_z;

    for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
        localparam int SRC = p / 2;
        localparam bit NEG = (p % 2) == 1;

        always_comb begin
            for (int k = 0; k < NUM_AXES; k++) begin
                n_plane[p].n[k] = NEG ? row_elem(r_row_w, k) - row_elem(src_row[SRC], k)
                                      : row_elem(r_row_w, k) + row_elem(src_row[SRC], k);
            end
            n_plane[p].d    = NEG ? row_elem(r_row_w, NUM_AXES) - row_elem(src_row[SRC], NUM_AXES)
                                  : row_elem(r_row_w, NUM_AXES) + row_elem(src_row[SRC], NUM_AXES);
            n_plane[p].zero = (n_plane[p].n == '0);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_plane[p] <= '{n: '0, d: '0, zero: 1'b1};
            end else begin
                r_plane[p] <= n_plane[p];
            end
        end

        assign o_plane[p] = r_plane[p];
    end

endmodule

[rtl/core/fac_dot.sv]
`timescale 1ns / 1ps

module fac_dot (
    input  logic                                    i_clk,
    input  fac_pkg::t_stage_ctl                     i_ctl,
    input  fac_pkg::t_plane                         i_plane,
    input  fac_pkg::t_coord [fac_pkg::NUM_AXES-1:0] i_lo,
    input  fac_pkg::t_coord [fac_pkg::NUM_AXES-1:0] i_hi,
    output logic                                    o_reject
);
    import fac_pkg::*;

    t_coord                    corner [NUM_AXES];
    logic signed [PROD_W-1:0]  n_prod [NUM_AXES];
    logic signed [PROD_W-1:0]  r_prod [NUM_AXES];
    logic signed [DSH_W-1:0]   n_dsh;
    logic signed [DSH_W-1:0]   r_dsh;
    logic                      r_live;
    logic signed [ACC_W-1:0]   n_acc;
    logic                      r_reject;

    always_comb begin
        for (int k = 0; k < NUM_AXES; k++) begin
            corner[k] = i_plane.n[k][COEF_W-1] ? $signed(i_lo[k]) : $signed(i_hi[k]);
            n_prod[k] = PROD_W'($signed(i_plane.n[k])) * PROD_W'($signed(corner[k]));
        end
        n_dsh = {i_plane.d, {D_SHIFT{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_mul) begin
            r_prod <= n_prod;
            r_dsh  <= n_dsh;
            r_live <= !i_plane.zero;
        end
    end

    assign n_acc = ACC_W'(r_prod[0]) + ACC_W'(r_prod[1]) + ACC_W'(r_prod[2]) + ACC_W'(r_dsh);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_sum) begin
            r_reject <= r_live && n_acc[ACC_W-1];
        end
    end

    assign o_reject = r_reject;

endmodule

[rtl/core/frustum_aabb_cull.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake           Beat
// in        input      i_valid / o_ready   i_box_min_{x,y,z}, i_box_max_{x,y,z}
// out       output     o_valid / i_ready   o_box_visible, o_box_invalid
// cfg       input      i_cfg_we            i_cfg_idx, i_cfg_data
//
// One beat per cycle unless the output stalls. Stages: capture, corner multiply,
// plane sum, output register. The 17x16 plane multipliers set the stage depth.
// Synchronous active-low reset clears the matrix rows and all valid bits.
// Each stage advances when it is empty or the next one advances; a stalled
// output holds its beat while earlier empty stages keep filling.

module frustum_aabb_cull (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [fac_pkg::ROW_IDX_W-1:0]  i_cfg_idx,
    input  logic [fac_pkg::ROW_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  fac_pkg::t_coord                i_box_min_x,
    input  fac_pkg::t_coord                i_box_min_y,
    input  fac_pkg::t_coord                i_box_min_z,
    input  fac_pkg::t_coord                i_box_max_x,
    input  fac_pkg::t_coord                i_box_max_y,
    input  fac_pkg::t_coord                i_box_max_z,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_box_visible,
    output logic                           o_box_invalid
);
    import fac_pkg::*;

    t_plane                  plane [NUM_PLANES];
    t_stage_ctl              ctl;
    logic [NUM_PLANES-1:0]   reject;

    logic                    adv1;
    logic                    adv2;
    logic                    adv3;
    logic                    adv_out;

    logic                    r_v1;
    logic                    r_v2;
    logic                    r_v3;
    logic                    r_ov;
    t_coord [NUM_AXES-1:0]   r_lo;
    t_coord [NUM_AXES-1:0]   r_hi;
    logic                    n_inv;
    logic                    r_inv1;
    logic                    r_inv2;
    logic                    r_inv3;
    logic                    r_visible;
    logic                    r_invalid;

    fac_plane u_plane (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_plane    (plane)
    );

    assign adv_out = !r_ov || i_ready;
    assign adv3    = !r_v3 || adv_out;
    assign adv2    = !r_v2 || adv3;
    assign adv1    = !r_v1 || adv2;
    assign o_ready = adv1;

    assign ctl.en_mul = adv2;
    assign ctl.en_sum = adv3;

    assign n_inv = (i_box_min_x > i_box_max_x) || (i_box_min_y > i_box_max_y)
                || (i_box_min_z > i_box_max_z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (adv1)    r_v1 <= i_valid;
            if (adv2)    r_v2 <= r_v1;
            if (adv3)    r_v3 <= r_v2;
            if (adv_out) r_ov <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_lo   <= {i_box_min_z, i_box_min_y, i_box_min_x};
            r_hi   <= {i_box_max_z, i_box_max_y, i_box_max_x};
            r_inv1 <= n_inv;
        end
        if (adv2) r_inv2 <= r_inv1;
        if (adv3) r_inv3 <= r_inv2;
        if (adv_out) begin
            r_visible <= r_inv3 || (reject == '0);
            r_invalid <= r_inv3;
        end
    end

    for (genvar p = 0; p < NUM_PLANES; p++) begin : g_dot
        fac_dot u_dot (
            .i_clk    (i_clk),
            .i_ctl    (ctl),
            .i_plane  (plane[p]),
            .i_lo     (r_lo),
            .i_hi     (r_hi),
            .o_reject (reject[p])
        );
    end

    assign o_valid       = r_ov;
    assign o_box_visible = r_visible;
    assign o_box_invalid = r_invalid;

endmodule

[rtl/core/fac_chk.sv]
`timescale 1ns / 1ps

module fac_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_ready,
    input logic o_valid,
    input logic i_ready,
    input logic o_box_visible,
    input logic o_box_invalid
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_box_visible) && $stable(o_box_invalid))
        else $error("output beat changed while stalled");

    a_invalid_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_box_invalid |-> o_box_visible)
        else $error("invalid box reported as culled");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with empty output");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind frustum_aabb_cull fac_chk u_fac_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_box_visible (o_box_visible),
    .o_box_invalid (o_box_invalid)
);

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import fac_pkg::*;

    localparam int LATENCY      = 4;
    localparam int STALL_CYCLES = 300;
    localparam int WDOG_LIMIT   = 3000;
    localparam int RAND_PER_SET = 210;

    typedef struct packed {
        t_coord [NUM_AXES-1:0] lo;
        t_coord [NUM_AXES-1:0] hi;
    } t_box;

    typedef struct packed {
        logic visible;
        logic invalid;
    } t_verdict;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   r_cfg_we = 1'b0;
    t_row_idx               r_cfg_idx = ROW_X;
    logic [ROW_DATA_W-1:0]  r_cfg_data = '0;
    logic                   r_valid = 1'b0;
    logic                   r_ready = 1'b0;
    t_coord                 r_min_x = '0;
    t_coord                 r_min_y = '0;
    t_coord                 r_min_z = '0;
    t_coord                 r_max_x = '0;
    t_coord                 r_max_y = '0;
    t_coord                 r_max_z = '0;
    logic                   o_ready;
    logic                   o_valid;
    logic                   o_box_visible;
    logic                   o_box_invalid;

    logic [ROW_DATA_W-1:0]  matrix_rows [NUM_ROWS];
    t_verdict               verdict_q [$];
    int                     err_cnt = 0;
    int                     src_idle_pct = 0;
    int                     sink_stall_pct = 0;
    int                     idle_cycles = 0;
    bit                     stall_req = 1'b0;
    bit                     stall_active = 1'b0;

    frustum_aabb_cull uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (r_cfg_we),
        .i_cfg_idx     (r_cfg_idx),
        .i_cfg_data    (r_cfg_data),
        .i_valid       (r_valid),
        .o_ready       (o_ready),
        .i_box_min_x   (r_min_x),
        .i_box_min_y   (r_min_y),
        .i_box_min_z   (r_min_z),
        .i_box_max_x   (r_max_x),
        .i_box_max_y   (r_max_y),
        .i_box_max_z   (r_max_z),
        .o_valid       (o_valid),
        .i_ready       (r_ready),
        .o_box_visible (o_box_visible),
        .o_box_invalid (o_box_invalid)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic longint matrix_entry(input logic [ROW_DATA_W-1:0] row, input int col);
        logic signed [COORD_W-1:0] e;
        e = row[col*COORD_W +: COORD_W];
        return longint'(e);
    endfunction

    function automatic t_verdict cull_verdict(input t_box b);
        t_verdict v;
        longint   lo [NUM_AXES];
        longint   hi [NUM_AXES];
        longint   coef [4];
        longint   plane_acc;
        longint   sgn;
        int       src;
        v.invalid = 1'b0;
        v.visible = 1'b1;
        for (int a = 0; a < NUM_AXES; a++) begin
            lo[a] = longint'($signed(b.lo[a]));
            hi[a] = longint'($signed(b.hi[a]));
            if (lo[a] > hi[a]) v.invalid = 1'b1;
        end
        if (!v.invalid) begin
            for (int p = 0; p < NUM_PLANES; p++) begin
                src = p / 2;
                sgn = (p % 2 == 1) ? -1 : 1;
                for (int k = 0; k < 4; k++) begin
                    coef[k] = matrix_entry(matrix_rows[ROW_W], k)
                            + sgn * matrix_entry(matrix_rows[src], k);
                end
                if (coef[0] != 0 || coef[1] != 0 || coef[2] != 0) begin
                    plane_acc = coef[3] * 256;
                    for (int k = 0; k < NUM_AXES; k++) begin
                        plane_acc += coef[k] * ((coef[k] >= 0) ? hi[k] : lo[k]);
                    end
                    if (plane_acc < 0) v.visible = 1'b0;
                end
            end
        end
        return v;
    endfunction

    function automatic t_box make_box(input t_coord x0, input t_coord y0, input t_coord z0,
                                      input t_coord x1, input t_coord y1, input t_coord z1);
        t_box b;
        b.lo[0] = x0;
        b.lo[1] = y0;
        b.lo[2] = z0;
        b.hi[0] = x1;
        b.hi[1] = y1;
        b.hi[2] = z1;
        return b;
    endfunction

    function automatic logic [ROW_DATA_W-1:0] pack_row(input t_coord e0, input t_coord e1,
                                                       input t_coord e2, input t_coord e3);
        return {e3, e2, e1, e0};
    endfunction

    task automatic report_error(input string msg);
        $display("error at %0t: %s", $time, msg);
        err_cnt++;
    endtask

    task automatic write_row(input t_row_idx idx, input logic [ROW_DATA_W-1:0] value);
        @(negedge i_clk);
        r_cfg_we   <= 1'b1;
        r_cfg_idx  <= idx;
        r_cfg_data <= value;
        matrix_rows[idx] = value;
        @(negedge i_clk);
        r_cfg_we <= 1'b0;
    endtask

    task automatic load_matrix(input logic [ROW_DATA_W-1:0] rx, input logic [ROW_DATA_W-1:0] ry,
                               input logic [ROW_DATA_W-1:0] rz, input logic [ROW_DATA_W-1:0] rw);
        write_row(ROW_X, rx);
        write_row(ROW_Y, ry);
        write_row(ROW_Z, rz);
        write_row(ROW_W, rw);
    endtask

    // hold valid across back-to-back beats; drop it only on an idle cycle
    task automatic send_box(input t_box b);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            r_valid <= 1'b0;
            @(negedge i_clk);
        end
        r_valid <= 1'b1;
        r_min_x <= b.lo[0];
        r_min_y <= b.lo[1];
        r_min_z <= b.lo[2];
        r_max_x <= b.hi[0];
        r_max_y <= b.hi[1];
        r_max_z <= b.hi[2];
        do @(posedge i_clk); while (!o_ready);
        verdict_q.push_back(cull_verdict(b));
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        r_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    always @(negedge i_clk) begin
        r_ready <= !stall_active && ($urandom_range(99) >= sink_stall_pct);
    end

    initial begin
        forever begin
            wait (stall_req);
            stall_active = 1'b1;
            repeat (STALL_CYCLES) @(posedge i_clk);
            stall_active = 1'b0;
            stall_req = 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n && o_valid && r_ready) begin
            if (verdict_q.size() == 0) begin
                report_error("result beat with no box outstanding");
            end else begin
                want = verdict_q.pop_front();
                if (o_box_visible !== want.visible)
                    report_error($sformatf("box_visible got %b expected %b",
                                           o_box_visible, want.visible));
                if (o_box_invalid !== want.invalid)
                    report_error($sformatf("box_invalid got %b expected %b",
                                           o_box_invalid, want.invalid));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((r_valid && o_ready) || (o_valid && r_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    function automatic t_box random_box(input bit narrow);
        t_box   b;
        t_coord p;
        t_coord q;
        int     pick;
        for (int a = 0; a < NUM_AXES; a++) begin
            p = narrow ? t_coord'($urandom_range(2047) - 1024) : t_coord'($urandom);
            q = narrow ? t_coord'($urandom_range(2047) - 1024) : t_coord'($urandom);
            pick = $urandom_range(99);
            if (pick < 5) q = p;
            if (pick < 95 && p > q) begin
                b.lo[a] = q;
                b.hi[a] = p;
            end else begin
                b.lo[a] = p;
                b.hi[a] = q;
            end
        end
        return b;
    endfunction

    function automatic logic [ROW_DATA_W-1:0] random_row(input bit narrow);
        logic [ROW_DATA_W-1:0] r;
        if (narrow) begin
            r = pack_row(t_coord'($urandom_range(1023) - 512), t_coord'($urandom_range(1023) - 512),
                         t_coord'($urandom_range(1023) - 512), t_coord'($urandom_range(2047)));
        end else begin
            r = {$urandom, $urandom};
        end
        return r;
    endfunction

    task automatic test_reset_matrix();
        send_box(make_box(16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff));
        send_box(make_box(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff));
        send_box(make_box(16'sh0100, 16'sh0000, 16'sh0000, 16'sh00ff, 16'sh0000, 16'sh0000));
        send_box(make_box(16'sh0000, 16'sh0000, 16'sh7fff, 16'sh0000, 16'sh0000, 16'sh8000));
        wait_drained();
    endtask

    task automatic test_unit_frustum();
        load_matrix(pack_row(16'sh0100, 0, 0, 0), pack_row(0, 16'sh0100, 0, 0),
                    pack_row(0, 0, 16'sh0100, 0), pack_row(0, 0, 0, 16'sh0400));
        send_box(make_box(-16'sh0100, -16'sh0100, -16'sh0100, 16'sh0100, 16'sh0100, 16'sh0100));
        send_box(make_box(16'sh0500, 0, 0, 16'sh0600, 0, 0));
        send_box(make_box(-16'sh0600, 0, 0, -16'sh0500, 0, 0));
        send_box(make_box(0, 16'sh0401, 0, 0, 16'sh0800, 0));
        send_box(make_box(0, 0, -16'sh0800, 0, 0, -16'sh0401));
        send_box(make_box(16'sh0400, 16'sh0400, 16'sh0400, 16'sh0800, 16'sh0800, 16'sh0800));
        send_box(make_box(-16'sh4000, 0, 0, 16'sh4000, 0, 0));
        send_box(make_box(0, 16'sh0001, 0, 0, 16'sh0000, 0));
        wait_drained();
    endtask

    task automatic test_zero_normal();
        load_matrix(pack_row(0, 0, 0, -16'sh0800), pack_row(0, 16'sh0100, 0, 0),
                    pack_row(0, 0, 16'sh0100, 0), pack_row(0, 0, 0, 16'sh0400));
        send_box(make_box(16'sh1000, 0, 0, 16'sh2000, 0, 0));
        send_box(make_box(0, 16'sh1000, 0, 0, 16'sh2000, 0));
        wait_drained();
    endtask

    task automatic test_extreme_matrix();
        load_matrix({4{16'h8000}}, {4{16'h7fff}}, {4{16'h8000}}, {4{16'h8000}});
        send_box(make_box(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000));
        send_box(make_box(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff));
        wait_drained();
        load_matrix({4{16'h7fff}}, {4{16'h8000}}, {4{16'h7fff}}, {4{16'h7fff}});
        send_box(make_box(16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff));
        send_box(make_box(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff));
        wait_drained();
    endtask

    task automatic test_random_traffic();
        int  src_pct [4] = '{0, 63, 0, 34};
        int  snk_pct [4] = '{0, 0, 63, 34};
        bit  narrow;
        for (int ph = 0; ph < 4; ph++) begin
            narrow = (ph % 2 == 1);
            load_matrix(random_row(narrow), random_row(narrow),
                        random_row(narrow), random_row(narrow));
            if (ph == 2)
                write_row(ROW_X, {matrix_rows[ROW_W][63:48],
                                  ~matrix_rows[ROW_W][47:0] + 48'd1});
            src_idle_pct   = src_pct[ph];
            sink_stall_pct = snk_pct[ph];
            for (int n = 0; n < RAND_PER_SET; n++) begin
                send_box(random_box(narrow ? 1'b1 : ($urandom_range(3) != 0)));
            end
            wait_drained();
        end
        src_idle_pct   = 0;
        sink_stall_pct = 0;
    endtask

    task automatic test_backpressure();
        load_matrix(random_row(1'b1), random_row(1'b1), random_row(1'b1), random_row(1'b1));
        stall_req = 1'b1;
        for (int n = 0; n < 40; n++) send_box(random_box(1'b1));
        wait_drained();
        for (int n = 0; n < 20; n++) send_box(random_box(1'b1));
        wait_drained();
    endtask

    initial begin
        for (int r = 0; r < NUM_ROWS; r++) matrix_rows[r] = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_matrix();
        test_unit_frustum();
        test_zero_normal();
        test_extreme_matrix();
        test_random_traffic();
        test_backpressure();
        wait_drained();
        if (err_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
